>>> rtl/core/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Used by jsu_decode, jsu_fifo and json_string_unescape_top; no dependencies.

package jsu_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_TEXT = 2'd1,
      MODE_ESC  = 2'd2,
      MODE_HEX  = 2'd3
   } mode_type;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_NO_QUOTE = 3'd1;
   localparam logic [2:0] STATUS_BAD_ESC  = 3'd2;
   localparam logic [2:0] STATUS_BAD_HEX  = 3'd3;
   localparam logic [2:0] STATUS_END_ESC  = 3'd4;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_R = 8'h72;
   localparam logic [7:0] CH_T = 8'h74;
   localparam logic [7:0] CH_U = 8'h75;

   localparam logic [7:0] BYTE_BS = 8'h08;
   localparam logic [7:0] BYTE_FF = 8'h0C;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   localparam logic [15:0] UTF8_MAX1 = 16'h007F;
   localparam logic [15:0] UTF8_MAX2 = 16'h07FF;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       string_end;
      logic [2:0] status;
      logic       last;
   } rsp_entry_type;

   // decoder verdict for one request
   typedef struct packed {
      logic [1:0]              count;
      rsp_entry_type [2:0]     entry;
      mode_type                mode;
      logic [1:0]              hex_count;
      logic [15:0]             code_value;
   } dec_out_type;

endpackage

>>> rtl/core/json_string_unescape_top.sv
// Top level of the JSON string unescaper.
// Depends on jsu_pkg, jsu_decode and jsu_fifo.
//
// Usage:
//   req channel: one raw text byte per request (req_in_byte), taken at a
//   clock edge with req_valid high and req_stall low.
//   rsp channel: one result per transfer (decoded byte, string end flag,
//   status code, last flag), taken with rsp_valid high and rsp_stall low.
//   A request yields zero to three results; the final one carries last.
// Timing:
//   A request lands in the input register, is decoded from there and
//   written to the result buffer, from whose head its first result is offered.
//   One request is taken per cycle unless req_stall; a \u escape of six bytes
//   bursts up to three results, absorbed while silent bytes drain the buffer.
//   Decode waits until the buffer has room for three entries (fill at most
//   depth minus three), so only a receiver that falls behind stalls requests.
// Reset:
//   Synchronous, active high: parser returns to idle (awaiting the opening
//   quote), the input register and buffer empty.
// Stall:
//   A stalled rsp holds its result; the buffer fills, decode pauses and
//   req_stall rises while the input register holds a pending request.

module json_string_unescape_top #(
   parameter int LOG_DEPTH = 3
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_string_end,
   output logic [2:0] rsp_status,
   output logic       rsp_last
);

   localparam int DEPTH = 1 << LOG_DEPTH;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // parser state
   jsu_pkg::mode_type mode_ff, mode_in;
   logic [1:0]        hex_count_ff, hex_count_in;
   logic [15:0]       code_value_ff, code_value_in;

   jsu_pkg::dec_out_type   dec;
   jsu_pkg::rsp_entry_type head;
   logic [LOG_DEPTH:0]     fill;
   logic                   fire;
   logic                   accept;
   logic [1:0]             push_count;

   jsu_decode u_decode (
      .in_byte    (in_byte_ff),
      .mode       (mode_ff),
      .hex_count  (hex_count_ff),
      .code_value (code_value_ff),
      .dec        (dec)
   );

   // decode only when the buffer can take a full three-byte burst
   assign fire = in_valid_ff && (fill <= (LOG_DEPTH+1)'(DEPTH - 3));
   assign req_stall = in_valid_ff && !fire;
   assign accept = req_valid && !req_stall;
   assign push_count = fire ? dec.count : 2'd0;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      mode_in = fire ? dec.mode : mode_ff;
      hex_count_in = fire ? dec.hex_count : hex_count_ff;
      code_value_in = fire ? dec.code_value : code_value_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff <= jsu_pkg::MODE_IDLE;
         hex_count_ff <= 2'd0;
         code_value_ff <= 16'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff <= mode_in;
         hex_count_ff <= hex_count_in;
         code_value_ff <= code_value_in;
      end
   end

   jsu_fifo #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_entry (dec.entry),
      .pop        (!rsp_stall),
      .not_empty  (rsp_valid),
      .fill       (fill),
      .head       (head)
   );

   assign rsp_out_byte = head.out_byte;
   assign rsp_has_byte = head.has_byte;
   assign rsp_string_end = head.string_end;
   assign rsp_status = head.status;
   assign rsp_last = head.last;

endmodule

>>> rtl/core/jsu_decode.sv
// Combinational decode of one raw byte against the current parse state.
// Depends on jsu_pkg.

module jsu_decode (
   input  logic [7:0]        in_byte,
   input  jsu_pkg::mode_type mode,
   input  logic [1:0]        hex_count,
   input  logic [15:0]       code_value,
   output jsu_pkg::dec_out_type dec
);

   logic        hex_ok;
   logic [3:0]  hex_digit;
   logic [15:0] cp;

   always_comb begin
      hex_ok = 1'b1;
      hex_digit = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_digit = 4'(in_byte - 8'h30);
      end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
         hex_digit = 4'(in_byte - 8'h37);
      end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
         hex_digit = 4'(in_byte - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign cp = {code_value[11:0], hex_digit};

   // result helper: a single ok byte
   function automatic jsu_pkg::rsp_entry_type data_entry(input logic [7:0] b);
      jsu_pkg::rsp_entry_type e;
      e.out_byte = b;
      e.has_byte = 1'b1;
      e.string_end = 1'b0;
      e.status = jsu_pkg::STATUS_OK;
      e.last = 1'b0;
      return e;
   endfunction

   function automatic jsu_pkg::rsp_entry_type err_entry(input logic [2:0] st);
      jsu_pkg::rsp_entry_type e;
      e.out_byte = 8'd0;
      e.has_byte = 1'b0;
      e.string_end = 1'b0;
      e.status = st;
      e.last = 1'b1;
      return e;
   endfunction

   always_comb begin
      dec.count = 2'd0;
      dec.entry = '0;
      dec.mode = mode;
      dec.hex_count = hex_count;
      dec.code_value = code_value;

      case (mode)
         jsu_pkg::MODE_IDLE: begin
            if (in_byte == jsu_pkg::CH_SPACE ||
                (in_byte >= jsu_pkg::CH_TAB && in_byte <= jsu_pkg::CH_CR)) begin
               dec.count = 2'd0;
            end else if (in_byte == jsu_pkg::CH_QUOTE) begin
               dec.mode = jsu_pkg::MODE_TEXT;
            end else begin
               dec.count = 2'd1;
               dec.entry[0] = err_entry(jsu_pkg::STATUS_NO_QUOTE);
               dec.hex_count = 2'd0;
               dec.code_value = 16'd0;
            end
         end
         jsu_pkg::MODE_TEXT: begin
            if (in_byte == jsu_pkg::CH_QUOTE) begin
               dec.mode = jsu_pkg::MODE_IDLE;
               dec.count = 2'd1;
               dec.entry[0] = err_entry(jsu_pkg::STATUS_OK);
               dec.entry[0].string_end = 1'b1;
            end else if (in_byte == jsu_pkg::CH_BSLASH) begin
               dec.mode = jsu_pkg::MODE_ESC;
            end else begin
               dec.count = 2'd1;
               dec.entry[0] = data_entry(in_byte);
               dec.entry[0].last = 1'b1;
            end
         end
         jsu_pkg::MODE_ESC: begin
            dec.mode = jsu_pkg::MODE_TEXT;
            dec.count = 2'd1;
            case (in_byte)
               jsu_pkg::CH_QUOTE:  dec.entry[0] = data_entry(jsu_pkg::CH_QUOTE);
               jsu_pkg::CH_BSLASH: dec.entry[0] = data_entry(jsu_pkg::CH_BSLASH);
               jsu_pkg::CH_SLASH:  dec.entry[0] = data_entry(jsu_pkg::CH_SLASH);
               jsu_pkg::CH_B:      dec.entry[0] = data_entry(jsu_pkg::BYTE_BS);
               jsu_pkg::CH_F:      dec.entry[0] = data_entry(jsu_pkg::BYTE_FF);
               jsu_pkg::CH_N:      dec.entry[0] = data_entry(jsu_pkg::BYTE_LF);
               jsu_pkg::CH_R:      dec.entry[0] = data_entry(jsu_pkg::CH_CR);
               jsu_pkg::CH_T:      dec.entry[0] = data_entry(jsu_pkg::CH_TAB);
               jsu_pkg::CH_U: begin
                  dec.mode = jsu_pkg::MODE_HEX;
                  dec.count = 2'd0;
                  dec.hex_count = 2'd0;
                  dec.code_value = 16'd0;
               end
               default: begin
                  dec.mode = jsu_pkg::MODE_IDLE;
                  dec.entry[0] = err_entry(jsu_pkg::STATUS_BAD_ESC);
                  dec.hex_count = 2'd0;
                  dec.code_value = 16'd0;
               end
            endcase
            dec.entry[0].last = 1'b1;
         end
         default: begin
            if (!hex_ok) begin
               dec.mode = jsu_pkg::MODE_IDLE;
               dec.count = 2'd1;
               dec.entry[0] = err_entry((in_byte == jsu_pkg::CH_QUOTE) ?
                                        jsu_pkg::STATUS_END_ESC :
                                        jsu_pkg::STATUS_BAD_HEX);
               dec.hex_count = 2'd0;
               dec.code_value = 16'd0;
            end else if (hex_count != 2'd3) begin
               dec.code_value = cp;
               dec.hex_count = hex_count + 2'd1;
            end else begin
               dec.mode = jsu_pkg::MODE_TEXT;
               dec.hex_count = 2'd0;
               dec.code_value = 16'd0;
               if (cp <= jsu_pkg::UTF8_MAX1) begin
                  dec.count = 2'd1;
                  dec.entry[0] = data_entry(cp[7:0]);
                  dec.entry[0].last = 1'b1;
               end else if (cp <= jsu_pkg::UTF8_MAX2) begin
                  dec.count = 2'd2;
                  dec.entry[0] = data_entry({3'b110, cp[10:6]});
                  dec.entry[1] = data_entry({2'b10, cp[5:0]});
                  dec.entry[1].last = 1'b1;
               end else begin
                  dec.count = 2'd3;
                  dec.entry[0] = data_entry({4'b1110, cp[15:12]});
                  dec.entry[1] = data_entry({2'b10, cp[11:6]});
                  dec.entry[2] = data_entry({2'b10, cp[5:0]});
                  dec.entry[2].last = 1'b1;
               end
            end
         end
      endcase
   end

endmodule

>>> rtl/core/jsu_fifo.sv
// Result buffer: takes up to three entries per cycle, gives one per cycle while popped.
// Depends on jsu_pkg.

module jsu_fifo #(
   parameter int LOG_DEPTH = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_count,
   input  jsu_pkg::rsp_entry_type [2:0] push_entry,
   input  logic                   pop,
   output logic                   not_empty,
   output logic [LOG_DEPTH:0]     fill,
   output jsu_pkg::rsp_entry_type head
);

   localparam int DEPTH = 1 << LOG_DEPTH;

   jsu_pkg::rsp_entry_type mem_ff [DEPTH];
   logic [LOG_DEPTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [LOG_DEPTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LOG_DEPTH:0]   count_ff, count_in;
   logic                 do_pop;

   assign not_empty = (count_ff != '0);
   assign fill = count_ff;
   assign head = mem_ff[rd_ptr_ff];
   assign do_pop = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + LOG_DEPTH'(push_count);
      rd_ptr_in = rd_ptr_ff + LOG_DEPTH'(do_pop);
      count_in = count_ff + (LOG_DEPTH+1)'(push_count) - (LOG_DEPTH+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (2'(k) < push_count) begin
            mem_ff[wr_ptr_ff + LOG_DEPTH'(k)] <= push_entry[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> sim/tb_top.sv
// Testbench for json_string_unescape_top: directed and random JSON text bytes,
// results checked against an in-bench unescape predictor.
// Depends on jsu_pkg and the RTL of json_string_unescape_top.

module tb_top;

   // ---------------------------------------------------------------------
   // DUT ports. Every input starts at a known value.
   // ---------------------------------------------------------------------
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_string_end;
   logic [2:0] rsp_status;
   logic       rsp_last;

   json_string_unescape_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_string_end (rsp_string_end),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   // 10 unit period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   jsu_pkg::rsp_entry_type decoded_q [$];  // results still owed by the block, oldest first
   int            fail_count    = 0;
   int            requests_sent = 0;
   bit            idle_on       = 1'b1;  // random gaps on both sides
   int            hold_request  = 0;     // asks the receiver for a long hold-off
   int            hold_left     = 0;     // receiver's own countdown

   // parser state mirrored by the predictor
   jsu_pkg::mode_type text_mode    = jsu_pkg::MODE_IDLE;
   logic [1:0]        digits_taken = 2'd0;
   logic [15:0]       code_acc     = 16'h0000;

   logic [7:0] escape_chars [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                    jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                                    jsu_pkg::CH_F, jsu_pkg::CH_N,
                                    jsu_pkg::CH_R, jsu_pkg::CH_T};

   // ---------------------------------------------------------------------
   // Predictor helpers
   // ---------------------------------------------------------------------
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      return -1;
   endfunction

   function automatic bit is_space(input logic [7:0] c);
      return c == jsu_pkg::CH_SPACE || (c >= jsu_pkg::CH_TAB && c <= jsu_pkg::CH_CR);
   endfunction

   function automatic jsu_pkg::rsp_entry_type data_result(input logic [7:0] b);
      return '{out_byte: b, has_byte: 1'b1, string_end: 1'b0,
               status: jsu_pkg::STATUS_OK, last: 1'b0};
   endfunction

   // any error drops the parser back to idle
   function automatic jsu_pkg::rsp_entry_type abort_parse(input logic [2:0] code);
      text_mode    = jsu_pkg::MODE_IDLE;
      digits_taken = 2'd0;
      code_acc     = 16'h0000;
      return '{out_byte: 8'h00, has_byte: 1'b0, string_end: 1'b0,
               status: code, last: 1'b0};
   endfunction

   // Work out the results one accepted request causes and queue them.
   task automatic predict_request(input logic [7:0] c);
      jsu_pkg::rsp_entry_type res [3];
      int                     n;
      int                     v;
      logic [3:0]             nib;
      n = 0;
      case (text_mode)
         jsu_pkg::MODE_IDLE: begin
            if (c == jsu_pkg::CH_QUOTE) begin
               text_mode = jsu_pkg::MODE_TEXT;
            end else if (!is_space(c)) begin
               res[0] = abort_parse(jsu_pkg::STATUS_NO_QUOTE);
               n = 1;
            end
         end
         jsu_pkg::MODE_TEXT: begin
            if (c == jsu_pkg::CH_QUOTE) begin
               text_mode = jsu_pkg::MODE_IDLE;
               res[0] = '{out_byte: 8'h00, has_byte: 1'b0, string_end: 1'b1,
                          status: jsu_pkg::STATUS_OK, last: 1'b0};
               n = 1;
            end else if (c == jsu_pkg::CH_BSLASH) begin
               text_mode = jsu_pkg::MODE_ESC;
            end else begin
               res[0] = data_result(c);
               n = 1;
            end
         end
         jsu_pkg::MODE_ESC: begin
            n = 1;
            text_mode = jsu_pkg::MODE_TEXT;
            case (c)
               jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                  res[0] = data_result(c);
               jsu_pkg::CH_B: res[0] = data_result(jsu_pkg::BYTE_BS);
               jsu_pkg::CH_F: res[0] = data_result(jsu_pkg::BYTE_FF);
               jsu_pkg::CH_N: res[0] = data_result(jsu_pkg::BYTE_LF);
               jsu_pkg::CH_R: res[0] = data_result(jsu_pkg::CH_CR);
               jsu_pkg::CH_T: res[0] = data_result(jsu_pkg::CH_TAB);
               jsu_pkg::CH_U: begin
                  text_mode    = jsu_pkg::MODE_HEX;
                  digits_taken = 2'd0;
                  code_acc     = 16'h0000;
                  n = 0;
               end
               default: res[0] = abort_parse(jsu_pkg::STATUS_BAD_ESC);
            endcase
         end
         default: begin
            v = hex_nibble(c);
            if (v < 0) begin
               res[0] = abort_parse(c == jsu_pkg::CH_QUOTE ? jsu_pkg::STATUS_END_ESC :
                                                             jsu_pkg::STATUS_BAD_HEX);
               n = 1;
            end else begin
               nib = 4'(v);
               code_acc = {code_acc[11:0], nib};
               if (digits_taken < 2'd3) begin
                  digits_taken = digits_taken + 2'd1;
               end else begin
                  // UTF-8 of the 16-bit code, no surrogate pairing
                  if (code_acc <= jsu_pkg::UTF8_MAX1) begin
                     res[0] = data_result(code_acc[7:0]);
                     n = 1;
                  end else if (code_acc <= jsu_pkg::UTF8_MAX2) begin
                     res[0] = data_result({3'b110, code_acc[10:6]});
                     res[1] = data_result({2'b10, code_acc[5:0]});
                     n = 2;
                  end else begin
                     res[0] = data_result({4'b1110, code_acc[15:12]});
                     res[1] = data_result({2'b10, code_acc[11:6]});
                     res[2] = data_result({2'b10, code_acc[5:0]});
                     n = 3;
                  end
                  text_mode    = jsu_pkg::MODE_TEXT;
                  digits_taken = 2'd0;
                  code_acc     = 16'h0000;
               end
            end
         end
      endcase
      if (n > 0) begin
         res[n-1].last = 1'b1;
         for (int i = 0; i < n; i++) decoded_q = {decoded_q, res[i]};
      end
   endtask

   // ---------------------------------------------------------------------
   // Request side. Inputs move on the falling edge; the request counts as
   // taken at the first rising edge with req_stall low. Valid stays high
   // after acceptance until the next falling edge decides what comes next.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [7:0] b);
      while (idle_on && $urandom_range(99) < 19) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_request(b);
      requests_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(s[i]);
   endtask

   // drop valid, then hold the sender until every owed result is in
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Random content
   // ---------------------------------------------------------------------
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + nib;
      if ($urandom_range(1)) return 8'h41 + nib - 8'd10;
      return 8'h61 + nib - 8'd10;
   endfunction

   function automatic bit is_escape_char(input logic [7:0] c);
      case (c)
         jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
         jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R,
         jsu_pkg::CH_T, jsu_pkg::CH_U: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] random_space();
      if ($urandom_range(5) == 0) return jsu_pkg::CH_SPACE;
      return 8'($urandom_range(jsu_pkg::CH_TAB, jsu_pkg::CH_CR));
   endfunction

   // any byte except the two that start or end something
   function automatic logic [7:0] random_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
      return b;
   endfunction

   // spread over the 1/2/3-byte UTF-8 classes, boundaries weighted up
   function automatic logic [15:0] random_code();
      logic [15:0] corner_codes [6] = '{16'h0000, 16'h007F, 16'h0080,
                                        16'h07FF, 16'h0800, 16'hFFFF};
      case ($urandom_range(3))
         0:       return corner_codes[$urandom_range(5)];
         1:       return 16'($urandom_range(16'h0000, 16'h007F));
         2:       return 16'($urandom_range(16'h0080, 16'h07FF));
         default: return 16'($urandom_range(16'h0800, 16'hFFFF));
      endcase
   endfunction

   task automatic send_unicode(input logic [15:0] code);
      send_request(jsu_pkg::CH_BSLASH);
      send_request(jsu_pkg::CH_U);
      for (int i = 3; i >= 0; i--) send_request(hex_char(code[i*4 +: 4]));
   endtask

   // bad escape, bad hex digit, or quote inside \u; each ends the string
   task automatic send_broken_escape();
      logic [7:0] b;
      int         kind;
      kind = $urandom_range(2);
      send_request(jsu_pkg::CH_BSLASH);
      if (kind == 0) begin
         do b = 8'($urandom_range(255)); while (is_escape_char(b));
         send_request(b);
      end else begin
         send_request(jsu_pkg::CH_U);
         repeat ($urandom_range(3)) send_request(hex_char(4'($urandom_range(15))));
         if (kind == 1) begin
            do b = 8'($urandom_range(255));
            while (hex_nibble(b) >= 0 || b == jsu_pkg::CH_QUOTE);
            send_request(b);
         end else begin
            send_request(jsu_pkg::CH_QUOTE);
         end
      end
   endtask

   // Mostly well formed strings with random content; some raw noise and
   // some strings cut short by a broken escape.
   task automatic send_random_string();
      int kind;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 6)) send_request(8'($urandom_range(255)));
         return;
      end
      repeat ($urandom_range(2)) send_request(random_space());
      send_request(jsu_pkg::CH_QUOTE);
      repeat ($urandom_range(10)) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            send_request(random_plain());
         end else if (kind < 65) begin
            send_request(jsu_pkg::CH_BSLASH);
            send_request(escape_chars[$urandom_range(7)]);
         end else if (kind < 93) begin
            send_unicode(random_code());
         end else begin
            send_broken_escape();
            return;
         end
      end
      send_request(jsu_pkg::CH_QUOTE);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // whitespace is skipped while idle, anything else but a quote is garbage
   task automatic test_idle_bytes();
      send_request(jsu_pkg::CH_SPACE);
      send_request(jsu_pkg::CH_CR);
      send_request(8'h00);
      send_request(8'hFF);
      wait_drained();
   endtask

   // all eight short escapes, then raw control and high bytes pass through
   task automatic test_simple_escapes();
      send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t");
      send_request(8'h01);
      send_request(8'h80);
      send_request(jsu_pkg::CH_QUOTE);
      wait_drained();
   endtask

   // two- and three-byte UTF-8 at their top codes, mixed-case hex
   task automatic test_unicode();
      send_text("\"\\u07fF\\uFFFF\"");
      wait_drained();
   endtask

   // unknown escape, bad hex digit, quote right after \u
   task automatic test_escape_errors();
      send_text("\"\\q");
      send_text("\"\\u1g");
      send_text("\"\\u\"");
      wait_drained();
   endtask

   // receiver holds off long enough to fill the result buffer and push
   // back on the request side while the sender keeps offering
   task automatic test_backpressure();
      int start;
      start = requests_sent;
      hold_request = 80;
      while (requests_sent - start < 40) send_random_string();
      wait_drained();
   endtask

   task automatic test_random_strings(input int count);
      int start;
      start = requests_sent;
      while (requests_sent - start < count) send_random_string();
      wait_drained();
   endtask

   // back to back on both sides
   task automatic test_no_idle_stretch();
      int start;
      idle_on = 1'b0;
      start = requests_sent;
      while (requests_sent - start < 100) send_random_string();
      wait_drained();
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, or a counted hold-off when asked.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 19);
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
      end
   endfunction

   // every taken result against the oldest owed one
   always @(posedge clock) begin
      jsu_pkg::rsp_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result: expected none, actual byte=%02h has=%0b",
                     $time, rsp_out_byte, rsp_has_byte);
            $display("%0t:    end=%0b status=%0d last=%0b",
                     $time, rsp_string_end, rsp_status, rsp_last);
         end else begin
            want = decoded_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("has_byte", 8'(want.has_byte), 8'(rsp_has_byte));
            check_field("string_end", 8'(want.string_end), 8'(rsp_string_end));
            check_field("status", 8'(want.status), 8'(rsp_status));
            check_field("last", 8'(want.last), 8'(rsp_last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_bytes();
      test_simple_escapes();
      test_unicode();
      test_escape_errors();
      test_backpressure();
      test_random_strings(300);
      test_no_idle_stretch();

      // wait_drained above already let the pipeline run dry
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
